>>> rtl/rtcm_frame_type_filter_unit_macros.svh
// Assertion macros for the RTCM3 frame filter.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef RTCM_FRAME_TYPE_FILTER_UNIT_MACROS_SVH
`define RTCM_FRAME_TYPE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RTCMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtcmf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RTCMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtcmf: next-cycle check failed");

`endif

>>> rtl/rtcmf_pkg.sv
// Package for the RTCM3 frame filter: framing constants, register indexes
// and the result-burst type shared by the top level and the output buffer.
package rtcmf_pkg;

  // Frame layout.
  localparam logic [7:0]  PREAMBLE       = 8'hD3;
  localparam logic [15:0] LEN_MASK       = 16'h3FFF;
  localparam logic [11:0] TYPE_MASK      = 12'h0FFF;
  localparam int unsigned FRAME_OVERHEAD = 6;
  localparam int unsigned HDR_LEN        = 5;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TYPE_W  = 12;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned REM_W   = 15;
  localparam int unsigned FILL_W  = 3;
  localparam int unsigned CNT_W   = 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TCOUNT_W   = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_BASE = 3'd1;

  // A group of results caused by one input byte: one streamed byte or a
  // whole five-byte header. Entry 0 leaves first.
  typedef struct packed {
    logic [HDR_LEN-1:0][BYTE_W-1:0] bytes;
    logic [HDR_LEN-1:0]             last;
    logic [CNT_W-1:0]               count;
    logic [TYPE_W-1:0]              ftype;
  } burst_t;

endpackage

>>> rtl/rtcmf_outbuf.sv
// Output buffer of the RTCM3 frame filter: holds up to one header burst and
// shifts it out one transfer per cycle. Depends on rtcmf_pkg.
module rtcmf_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  rtcmf_pkg::burst_t           burst_i,
  output logic                        can_load_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rtcmf_pkg::BYTE_W-1:0] out_byte_o,
  output logic [rtcmf_pkg::TYPE_W-1:0] frame_type_o,
  output logic                        frame_last_o,
  output logic                        run_last_o
);

  logic [rtcmf_pkg::HDR_LEN-1:0][rtcmf_pkg::BYTE_W-1:0] slot_q, slot_d;
  logic [rtcmf_pkg::HDR_LEN-1:0]                        last_q, last_d;
  logic [rtcmf_pkg::CNT_W-1:0]                          cnt_q, cnt_d;
  logic [rtcmf_pkg::TYPE_W-1:0]                         type_q, type_d;
  logic                                                 take;

  // A transfer leaves entry 0; the buffer can be refilled once it drains.
  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = (cnt_q == '0) ||
                       ((cnt_q == rtcmf_pkg::CNT_W'(1)) && !out_stall_i);

  assign out_byte_o   = slot_q[0];
  assign frame_last_o = last_q[0];
  assign frame_type_o = type_q;
  assign run_last_o   = (cnt_q == rtcmf_pkg::CNT_W'(1));

  // Load a new burst or shift the current one down by one entry.
  always_comb begin
    slot_d = slot_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    type_d = type_q;
    if (load_i) begin
      slot_d = burst_i.bytes;
      last_d = burst_i.last;
      cnt_d  = burst_i.count;
      type_d = burst_i.ftype;
    end else if (take) begin
      for (int i = 0; i < rtcmf_pkg::HDR_LEN - 1; i++) begin
        slot_d[i] = slot_q[i+1];
        last_d[i] = last_q[i+1];
      end
      cnt_d = cnt_q - rtcmf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    last_q <= last_d;
    type_q <= type_d;
  end

endmodule

>>> rtl/rtcm_frame_type_filter_unit.sv
// RTCM3 frame filter: takes one received byte per transfer and forwards
// only frames whose 12-bit message type is among the first type_count wanted
// types. Each byte is handled in the cycle it is accepted, so the block takes
// one byte per cycle while the result side keeps up; a wanted header puts
// five results into the output buffer, and input transfers wait for that buffer
// (its last entry may leave in the cycle the next byte is taken). A partial
// header at the end of a buffer is dropped, and a frame cut by a buffer end is
// forwarded truncated with frame_last set on its final byte. No CRC is checked.
// Depends on rtcmf_pkg, rtcmf_outbuf and rtcm_frame_type_filter_unit_macros.svh.
`include "rtcm_frame_type_filter_unit_macros.svh"

module rtcm_frame_type_filter_unit #(
  parameter int unsigned MAX_TYPES = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes.
  input  logic                            cfg_we_i,
  input  logic [rtcmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rtcmf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Byte input.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rtcmf_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic                            buffer_end_i,
  // Result output.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rtcmf_pkg::BYTE_W-1:0]    out_byte_o,
  output logic [rtcmf_pkg::TYPE_W-1:0]    frame_type_o,
  output logic                            frame_last_o,
  output logic                            run_last_o
);

  logic [rtcmf_pkg::TCOUNT_W-1:0]                        tcount_q;
  logic [MAX_TYPES-1:0][rtcmf_pkg::TYPE_W-1:0]           wanted_q;
  logic [rtcmf_pkg::HDR_LEN-1:0][rtcmf_pkg::BYTE_W-1:0]  win_q, win_d, win_app;
  logic [rtcmf_pkg::FILL_W-1:0]                          fill_q, fill_d, fill_app;
  logic [rtcmf_pkg::REM_W-1:0]                           rem_q, rem_d, rem_hdr;
  logic [rtcmf_pkg::TYPE_W-1:0]                          ctype_q, ctype_d, hdr_type;
  logic [rtcmf_pkg::LEN_W-1:0]                           hdr_len;
  logic                                                  hdr_wanted;
  logic                                                  accept;
  logic                                                  can_load;
  logic                                                  load;
  rtcmf_pkg::burst_t                                     burst;

  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;

  // Configuration registers; writes to wanted types past MAX_TYPES are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= '0;
      wanted_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rtcmf_pkg::CFG_TYPE_COUNT) begin
        tcount_q <= cfg_wdata_i[rtcmf_pkg::TCOUNT_W-1:0];
      end
      for (int i = 0; i < MAX_TYPES; i++) begin
        if (cfg_idx_i == rtcmf_pkg::CFG_WANTED_BASE + rtcmf_pkg::CFG_IDX_W'(i)) begin
          wanted_q[i] <= cfg_wdata_i & rtcmf_pkg::TYPE_MASK;
        end
      end
    end
  end

  // Window with the new byte appended; the hunt only starts on a preamble.
  always_comb begin
    win_app  = win_q;
    fill_app = fill_q;
    if (fill_q != '0 || rx_byte_i == rtcmf_pkg::PREAMBLE) begin
      case (fill_q)
        3'd0:    win_app[0] = rx_byte_i;
        3'd1:    win_app[1] = rx_byte_i;
        3'd2:    win_app[2] = rx_byte_i;
        3'd3:    win_app[3] = rx_byte_i;
        default: win_app[4] = rx_byte_i;
      endcase
      fill_app = fill_q + rtcmf_pkg::FILL_W'(1);
    end
  end

  // Header fields and the type match against the wanted registers in use.
  assign hdr_type = rtcmf_pkg::TYPE_W'({win_app[3], win_app[4][7:4]});
  assign hdr_len  = rtcmf_pkg::LEN_W'({win_app[1], win_app[2]} & rtcmf_pkg::LEN_MASK);
  assign rem_hdr  = rtcmf_pkg::REM_W'(hdr_len) +
                    rtcmf_pkg::REM_W'(rtcmf_pkg::FRAME_OVERHEAD - rtcmf_pkg::HDR_LEN);

  always_comb begin
    hdr_wanted = 1'b0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      if ((rtcmf_pkg::TCOUNT_W'(i) < tcount_q) && (wanted_q[i] == hdr_type)) begin
        hdr_wanted = 1'b1;
      end
    end
  end

  // Next state and the results caused by the accepted byte.
  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    ctype_d     = ctype_q;
    load        = 1'b0;
    burst       = '0;
    burst.ftype = ctype_q;
    if (rem_q != '0) begin
      // Streaming the body of a wanted frame.
      rem_d          = buffer_end_i ? '0 : rem_q - rtcmf_pkg::REM_W'(1);
      load           = 1'b1;
      burst.bytes[0] = rx_byte_i;
      burst.last[0]  = buffer_end_i || (rem_q == rtcmf_pkg::REM_W'(1));
      burst.count    = rtcmf_pkg::CNT_W'(1);
    end else begin
      win_d  = win_app;
      fill_d = fill_app;
      if (fill_app == rtcmf_pkg::FILL_W'(rtcmf_pkg::HDR_LEN)) begin
        if (hdr_wanted) begin
          ctype_d     = hdr_type;
          rem_d       = buffer_end_i ? '0 : rem_hdr;
          load        = 1'b1;
          burst.bytes = win_app;
          burst.last  = {buffer_end_i, 4'b0000};
          burst.count = rtcmf_pkg::CNT_W'(rtcmf_pkg::HDR_LEN);
          burst.ftype = hdr_type;
          fill_d      = '0;
        end else begin
          // Rejected header: drop the preamble, resync on the next one.
          if (win_app[1] == rtcmf_pkg::PREAMBLE) begin
            win_d[3:0] = win_app[4:1];
            fill_d     = rtcmf_pkg::FILL_W'(4);
          end else if (win_app[2] == rtcmf_pkg::PREAMBLE) begin
            win_d[2:0] = win_app[4:2];
            fill_d     = rtcmf_pkg::FILL_W'(3);
          end else if (win_app[3] == rtcmf_pkg::PREAMBLE) begin
            win_d[1:0] = win_app[4:3];
            fill_d     = rtcmf_pkg::FILL_W'(2);
          end else if (win_app[4] == rtcmf_pkg::PREAMBLE) begin
            win_d[0]   = win_app[4];
            fill_d     = rtcmf_pkg::FILL_W'(1);
          end else begin
            fill_d     = '0;
          end
        end
      end
      // A buffer end drops any partial header.
      if (buffer_end_i) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      rem_q   <= '0;
      ctype_q <= '0;
    end else if (accept) begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      ctype_q <= ctype_d;
    end
  end

  // Output buffer.
  rtcmf_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept && load),
    .burst_i      (burst),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_type_o (frame_type_o),
    .frame_last_o (frame_last_o),
    .run_last_o   (run_last_o)
  );

  // The header window stays empty while a frame body is streaming.
  `RTCMF_ASSERT_NOW(a_window_idle_in_body, rem_q != '0, fill_q == '0)
  // The window never holds a complete header between bytes.
  `RTCMF_ASSERT_NOW(a_window_partial, fill_q != '0, fill_q < rtcmf_pkg::FILL_W'(rtcmf_pkg::HDR_LEN))
  // A body byte appears at the head of the buffer in the next cycle.
  `RTCMF_ASSERT_NEXT(a_body_forwarded, accept && rem_q != '0, out_valid_o && out_byte_o == $past(rx_byte_i) && run_last_o)
  // Frame end is flagged exactly when the count runs out or the buffer ends.
  `RTCMF_ASSERT_NEXT(a_body_last, accept && rem_q != '0, frame_last_o == ($past(buffer_end_i) || $past(rem_q) == rtcmf_pkg::REM_W'(1)))

endmodule

>>> bench/rtcm_frame_type_filter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rtcm_frame_type_filter_unit: directed and random byte streams,
// predicted forwarding of wanted RTCM3 frames, random stalls on both sides.
// Depends on rtcmf_pkg and the RTL of the filter unit only.
module rtcm_frame_type_filter_unit_tb;

  localparam int MAX_TYPES  = 7;
  localparam int SETTLE     = 16;
  localparam int LIMIT      = 400_000;
  localparam int MAX_REPORT = 10;

  // One forwarded byte as it should leave the block.
  typedef struct packed {
    logic [rtcmf_pkg::BYTE_W-1:0] data;
    logic [rtcmf_pkg::TYPE_W-1:0] ftype;
    logic                         flast;
    logic                         rlast;
  } fwd_byte_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             cfg_we_i     = 1'b0;
  logic [rtcmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [rtcmf_pkg::CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic [rtcmf_pkg::BYTE_W-1:0]     rx_byte_i    = '0;
  logic                             buffer_end_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic [rtcmf_pkg::BYTE_W-1:0]     out_byte_o;
  logic [rtcmf_pkg::TYPE_W-1:0]     frame_type_o;
  logic                             frame_last_o;
  logic                             run_last_o;

  // Filter state as predicted from the accepted byte stream.
  fwd_byte_t                    forwarded_q [$];
  logic [rtcmf_pkg::BYTE_W-1:0] hdr_win [rtcmf_pkg::HDR_LEN];
  int                           win_fill   = 0;
  int                           bytes_left = 0;
  logic [rtcmf_pkg::TYPE_W-1:0] fwd_type   = '0;
  logic [2:0]                   type_count = '0;
  logic [rtcmf_pkg::TYPE_W-1:0] wanted_types [MAX_TYPES];

  // Run bookkeeping and idling control.
  int   failures      = 0;
  int   results_seen  = 0;
  int   bytes_sent    = 0;
  int   frame_bytes   = 0;
  int   settings_used = 0;
  int   cycle_count   = 0;
  bit   tx_steady     = 1'b0;
  bit   rx_steady     = 1'b0;
  int   hold_requests = 0;
  int   hold_taken    = 0;
  int   hold_cycles   = 0;
  int   hold_left     = 0;
  int   stall_left    = 0;
  int   run_left      = 0;

  rtcm_frame_type_filter_unit #(
    .MAX_TYPES(MAX_TYPES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .buffer_end_i(buffer_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_type_o(frame_type_o),
    .frame_last_o(frame_last_o),
    .run_last_o  (run_last_o)
  );

  always #4 clk_i = ~clk_i;

  // Abort the run if it goes on far longer than the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               forwarded_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic type_is_wanted(input logic [rtcmf_pkg::TYPE_W-1:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      if (i < int'(type_count) && wanted_types[i] == t) hit = 1'b1;
    end
    return hit;
  endfunction

  // A rejected header loses its preamble; the hunt resumes at the next preamble in the window.
  function automatic void drop_preamble();
    int k;
    k = 1;
    while (k < win_fill && hdr_win[k] != rtcmf_pkg::PREAMBLE) k++;
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int j = 0; j + k < win_fill; j++) hdr_win[j] = hdr_win[j + k];
      win_fill -= k;
    end
  endfunction

  // Advance the predicted filter by one accepted byte and queue what it forwards.
  function automatic void filter_byte(input logic [rtcmf_pkg::BYTE_W-1:0] b, input logic e);
    logic [rtcmf_pkg::TYPE_W-1:0] t;
    int flen;
    if (bytes_left > 0) begin
      bytes_left = e ? 0 : bytes_left - 1;
      forwarded_q.push_back('{b, fwd_type, bytes_left == 0, 1'b1});
    end else begin
      if (win_fill == 0) begin
        if (b == rtcmf_pkg::PREAMBLE) begin
          hdr_win[0] = b;
          win_fill = 1;
        end
      end else begin
        hdr_win[win_fill] = b;
        win_fill++;
      end
      if (win_fill == rtcmf_pkg::HDR_LEN) begin
        t = {hdr_win[3], hdr_win[4][7:4]};
        flen = int'({hdr_win[1], hdr_win[2]} & rtcmf_pkg::LEN_MASK) +
               rtcmf_pkg::FRAME_OVERHEAD;
        if (type_is_wanted(t)) begin
          fwd_type = t;
          bytes_left = e ? 0 : flen - rtcmf_pkg::HDR_LEN;
          for (int i = 0; i < rtcmf_pkg::HDR_LEN; i++) begin
            forwarded_q.push_back('{hdr_win[i], t,
                                    i == rtcmf_pkg::HDR_LEN - 1 && bytes_left == 0,
                                    i == rtcmf_pkg::HDR_LEN - 1});
          end
          win_fill = 0;
        end else begin
          drop_preamble();
        end
      end
      if (e) win_fill = 0;
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORT) $display("%s", msg);
  endfunction

  // Predict on each input transfer, then check each output transfer against the oldest
  // expectation. Both are sampled at the same edge so a same-cycle result is still ordered.
  always @(posedge clk_i) begin : check_results
    fwd_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) filter_byte(rx_byte_i, buffer_end_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (forwarded_q.size() == 0) begin
          note_failure($sformatf("Cycle %0d: unexpected result byte %02h type %03h",
                                 cycle_count, out_byte_o, frame_type_o));
        end else begin
          want = forwarded_q.pop_front();
          if (out_byte_o !== want.data || frame_type_o !== want.ftype ||
              frame_last_o !== want.flast || run_last_o !== want.rlast) begin
            note_failure($sformatf({"Cycle %0d: expected byte %02h type %03h frame_last %0b ",
                                    "run_last %0b, got %02h %03h %0b %0b"},
                                   cycle_count, want.data, want.ftype, want.flast, want.rlast,
                                   out_byte_o, frame_type_o, frame_last_o, run_last_o));
          end
        end
      end
    end
  end

  // Receiver side: random stall bursts, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left = hold_cycles;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (rx_steady) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall_i <= 1'b0;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_stall_i <= 1'b0;
      run_left = $urandom_range(1, 40) - 1;
    end
  end

  // Offer one byte, possibly after an idle burst, and return once it has been transferred.
  // Valid stays high afterwards so that back-to-back bytes need no extra assignment.
  task automatic send_byte(input logic [rtcmf_pkg::BYTE_W-1:0] b, input logic e);
    int gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    buffer_end_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Send the low n bytes of seq, most significant first.
  task automatic send_run(input logic [63:0] seq, input int n, input logic end_last);
    for (int i = 0; i < n; i++) send_byte(seq[8 * (n - 1 - i) +: 8], end_last && i == n - 1);
  endtask

  // Stop offering bytes and wait until every predicted result has left the block.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (forwarded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rtcmf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtcmf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rtcmf_pkg::CFG_TYPE_COUNT) type_count = data[rtcmf_pkg::TCOUNT_W-1:0];
    else wanted_types[idx - rtcmf_pkg::CFG_WANTED_BASE] = data[rtcmf_pkg::TYPE_W-1:0];
  endtask

  // Load all wanted types (type 0 in the low bits) and the count in use.
  task automatic set_filter(input logic [2:0] n,
                            input logic [MAX_TYPES*rtcmf_pkg::TYPE_W-1:0] types);
    for (int i = 0; i < MAX_TYPES; i++) begin
      write_reg(rtcmf_pkg::CFG_WANTED_BASE + rtcmf_pkg::CFG_IDX_W'(i),
                rtcmf_pkg::CFG_DATA_W'(types[rtcmf_pkg::TYPE_W * i +: rtcmf_pkg::TYPE_W]));
    end
    write_reg(rtcmf_pkg::CFG_TYPE_COUNT, rtcmf_pkg::CFG_DATA_W'(n));
    settings_used++;
  endtask

  function automatic logic [MAX_TYPES*rtcmf_pkg::TYPE_W-1:0] random_types();
    return (MAX_TYPES*rtcmf_pkg::TYPE_W)'({$urandom(), $urandom(), $urandom()});
  endfunction

  // Well-formed frame with random payload; cut >= 0 ends the buffer at that byte.
  task automatic send_frame(input logic [rtcmf_pkg::TYPE_W-1:0] t, input int len,
                            input int cut);
    logic [rtcmf_pkg::BYTE_W-1:0] b;
    int total;
    total = len + rtcmf_pkg::FRAME_OVERHEAD;
    for (int i = 0; i < total; i++) begin
      case (i)
        0: b = rtcmf_pkg::PREAMBLE;
        1: b = {2'($urandom), 6'(len >> 8)};
        2: b = 8'(len);
        3: b = t[11:4];
        4: b = {t[3:0], 4'($urandom)};
        default: b = ($urandom_range(0, 7) == 0) ? rtcmf_pkg::PREAMBLE : 8'($urandom);
      endcase
      frame_bytes++;
      if (i == cut) begin
        send_byte(b, 1'b1);
        break;
      end
      send_byte(b, i == total - 1 && $urandom_range(0, 3) == 0);
    end
  endtask

  // Mostly wanted types; long frames are always cut short by a buffer end.
  task automatic send_random_frame();
    logic [rtcmf_pkg::TYPE_W-1:0] t;
    int len;
    int cut;
    case ($urandom_range(0, 9))
      0, 1: t = rtcmf_pkg::TYPE_W'($urandom);
      2, 3: t = wanted_types[$urandom_range(0, MAX_TYPES - 1)];
      default: t = (type_count != 0) ? wanted_types[$urandom_range(0, int'(type_count) - 1)]
                                     : rtcmf_pkg::TYPE_W'($urandom);
    endcase
    cut = -1;
    if ($urandom_range(0, 11) == 0) begin
      len = $urandom_range(0, 16383);
      cut = $urandom_range(0, 12);
    end else begin
      len = $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, len + 5);
    end
    send_frame(t, len, cut);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_byte(($urandom_range(0, 4) == 0) ? rtcmf_pkg::PREAMBLE : 8'($urandom),
                $urandom_range(0, 9) == 0);
    end
  endtask

  // Frames and noise until n frame bytes have gone; a closing buffer end flushes the filter.
  task automatic run_random_phase(input int n);
    int start;
    start = frame_bytes;
    while (frame_bytes - start < n) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_frame();
    end
    send_byte(8'($urandom), 1'b1);
    wait_drained();
  endtask

  // Two wanted types in use; type 0 sits in a register beyond the count.
  task automatic test_type_setup();
    set_filter(3'd2, {12'd1077, 12'd1230, 12'd1127, 12'd1087, 12'd0, 12'hFFF, 12'h3ED});
  endtask

  // Shortest wanted frame: header burst then one streamed byte.
  task automatic test_wanted_frame();
    send_run({rtcmf_pkg::PREAMBLE, 40'h00_00_3E_D7_AA}, 6, 1'b0);
  endtask

  // Rejected header of type 0 whose window holds a second preamble to resume from.
  task automatic test_header_hunt();
    send_run({rtcmf_pkg::PREAMBLE, 8'h00, rtcmf_pkg::PREAMBLE, 40'h00_00_3E_D0_55}, 8, 1'b0);
  endtask

  // Partial header at a buffer end, header complete on a buffer end, and a truncated
  // frame of the largest length.
  task automatic test_buffer_end();
    send_run({rtcmf_pkg::PREAMBLE, 8'h05}, 2, 1'b1);
    send_run({rtcmf_pkg::PREAMBLE, 32'hC0_01_FF_F0}, 5, 1'b1);
    send_run({rtcmf_pkg::PREAMBLE, 48'h3F_FF_3E_D2_11_22}, 7, 1'b1);
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering wanted frames.
  task automatic test_backpressure();
    hold_cycles = 150;
    hold_requests++;
    tx_steady = 1'b1;
    repeat (6) send_frame(wanted_types[0], $urandom_range(0, 3), -1);
    tx_steady = 1'b0;
    wait_drained();
  endtask

  // Sender pauses mid-phase until all results are out, then carries on.
  task automatic test_drain_pause();
    repeat (3) send_random_frame();
    wait_drained();
    repeat (3) send_random_frame();
    send_byte(8'($urandom), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [MAX_TYPES*rtcmf_pkg::TYPE_W-1:0] types;
    types = random_types();
    set_filter(3'd7, {types[MAX_TYPES*rtcmf_pkg::TYPE_W-1:2*rtcmf_pkg::TYPE_W],
                      12'hFFF, 12'h000});
    run_random_phase(80);
    set_filter(3'd0, random_types());
    run_random_phase(30);
    set_filter(3'd1, random_types());
    run_random_phase(60);
    set_filter(3'($urandom_range(2, 6)), random_types());
    run_random_phase(70);
  endtask

  // Last part of the run with no idling on either side.
  task automatic test_steady_tail();
    rx_steady = 1'b1;
    tx_steady = 1'b1;
    set_filter(3'd7, random_types());
    run_random_phase(60);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_type_setup();
    test_wanted_frame();
    test_header_hunt();
    test_buffer_end();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    test_steady_tail();
    if (forwarded_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", forwarded_q.size()));
    end
    $display("Sent %0d bytes (%0d in frames) under %0d filter settings, with truncation,",
             bytes_sent, frame_bytes, settings_used);
    $display("header hunting and a long output hold-off; %0d results checked, %0d failures.",
             results_seen, failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
